### hdl/bptc_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
// No dependencies; used by bptc_csr and baro_pressure_temp_compensation.
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

   // Calibration register file
   localparam int CSR_IDX_W = 3;
   localparam int CAL_W     = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_SENS = 3'd0,
      CSR_PRESS_OFF  = 3'd1,
      CSR_SENS_TC    = 3'd2,
      CSR_OFF_TC     = 3'd3,
      CSR_REF_TEMP   = 3'd4,
      CSR_TEMP_TC    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sens_temp_coef;
      logic [CAL_W-1:0] offset_temp_coef;
      logic [CAL_W-1:0] reference_temp;
      logic [CAL_W-1:0] temp_coef;
   } cal_type;

   // Register stages from accepted word to result strobe
   localparam int LATENCY = 10;

   // Temperature breakpoints, as offsets and limits in 0.01 C
   localparam logic signed [18:0] TEMP_REF       = 19'sd2000;
   localparam logic signed [19:0] VERY_COLD_BIAS = 20'sd3500;
   localparam logic signed [18:0] TEMP_LO_LIMIT  = -19'sd4000;
   localparam logic signed [18:0] TEMP_HI_LIMIT  = 19'sd8500;

   // Pressure limits in 0.01 mbar
   localparam logic signed [28:0] PRESS_LO_LIMIT = 29'sd1000;
   localparam logic signed [28:0] PRESS_HI_LIMIT = 29'sd120000;

endpackage

`default_nettype wire

### hdl/bptc_csr.sv
// Calibration register file: six 16-bit words written over the csr channel.
// Depends on bptc_pkg (cal_type, csr_idx_type).
`timescale 1ns / 1ps
`default_nettype none

module bptc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bptc_pkg::CAL_W-1:0]       csr_data,
   output bptc_pkg::cal_type                     cal
);

   bptc_pkg::cal_type cal_ff;
   bptc_pkg::cal_type cal_in;

   // Always ready outside reset
   assign csr_ready = ~reset;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cal_in = cal_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bptc_pkg::CSR_PRESS_SENS: cal_in.pressure_sensitivity = csr_data;
            bptc_pkg::CSR_PRESS_OFF:  cal_in.pressure_offset      = csr_data;
            bptc_pkg::CSR_SENS_TC:    cal_in.sens_temp_coef       = csr_data;
            bptc_pkg::CSR_OFF_TC:     cal_in.offset_temp_coef     = csr_data;
            bptc_pkg::CSR_REF_TEMP:   cal_in.reference_temp       = csr_data;
            bptc_pkg::CSR_TEMP_TC:    cal_in.temp_coef            = csr_data;
            default:                  cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

`default_nettype wire

### hdl/baro_pressure_temp_compensation.sv
// Top level: ten-stage pipeline for second-order pressure/temperature compensation.
// Depends on bptc_pkg and bptc_csr.
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------------
//   req       start / busy          req_raw_pressure, req_raw_temperature
//   rsp       rsp_valid (strobe)    rsp_pressure_centi_mbar, rsp_temperature_centi_c,
//                                   rsp_pressure_out_of_range, rsp_temperature_out_of_range
//   csr       csr_valid / csr_ready csr_index, csr_data
//
// One word is taken per cycle while busy is low; its result is registered through the ten
// register stages and leaves with the rsp_valid strobe (the 40-bit by 24-bit product is
// split into two partial products and recombined over two stages).
// Synchronous reset clears the calibration words and every stage valid bit; busy is high
// during reset and for the cycle after it. There is no backpressure on rsp, so nothing stalls.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [23:0]                    req_raw_pressure,
   input  wire logic [23:0]                    req_raw_temperature,
   // response
   output logic                                rsp_valid,
   output logic signed [31:0]                  rsp_pressure_centi_mbar,
   output logic signed [18:0]                  rsp_temperature_centi_c,
   output logic                                rsp_pressure_out_of_range,
   output logic                                rsp_temperature_out_of_range,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bptc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bptc_pkg::CAL_W-1:0]     csr_data
);

   bptc_pkg::cal_type cal;

   logic                          busy_ff;
   logic                          accept;
   logic [bptc_pkg::LATENCY-1:0]  vld_ff;
   logic [bptc_pkg::LATENCY-1:0]  vld_in;

   bptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cal       (cal)
   );

   // Control: busy only during and right after reset, valid bits shift with the data
   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;
   assign vld_in = {vld_ff[bptc_pkg::LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   // ---------------- stage 1: dT = D2 - C5*256
   logic        [23:0] s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, cal.reference_temp, 8'd0});

   always_ff @(posedge clock) begin
      s1_d1_ff <= req_raw_pressure;
      s1_dt_ff <= s1_dt_in;
   end

   // ---------------- stage 2: the four dT products
   logic        [23:0] s2_d1_ff;
   logic signed [41:0] s2_mt_ff, s2_mt_in;
   logic signed [41:0] s2_mo_ff, s2_mo_in;
   logic signed [41:0] s2_ms_ff, s2_ms_in;
   logic signed [49:0] s2_mdd_ff, s2_mdd_in;

   assign s2_mt_in  = s1_dt_ff * $signed({1'b0, cal.temp_coef});
   assign s2_mo_in  = s1_dt_ff * $signed({1'b0, cal.offset_temp_coef});
   assign s2_ms_in  = s1_dt_ff * $signed({1'b0, cal.sens_temp_coef});
   assign s2_mdd_in = s1_dt_ff * s1_dt_ff;

   always_ff @(posedge clock) begin
      s2_d1_ff  <= s1_d1_ff;
      s2_mt_ff  <= s2_mt_in;
      s2_mo_ff  <= s2_mo_in;
      s2_ms_ff  <= s2_ms_in;
      s2_mdd_ff <= s2_mdd_in;
   end

   // ---------------- stage 3: first-order TEMP, OFF, SENS; T2; cold flags
   logic        [23:0] s3_d1_ff;
   logic signed [18:0] s3_dtemp;
   logic signed [18:0] s3_temp_ff, s3_temp_in;
   logic signed [18:0] s3_lo_ff;
   logic signed [19:0] s3_vl_ff, s3_vl_in;
   logic signed [36:0] s3_off_ff, s3_off_in;
   logic signed [35:0] s3_sens_ff, s3_sens_in;
   logic        [17:0] s3_t2_ff;
   logic               s3_cold_ff, s3_vcold_ff;

   // arithmetic shifts are upper-bit slices of the signed products
   assign s3_dtemp   = $signed(s2_mt_ff[41:23]);
   assign s3_temp_in = s3_dtemp + bptc_pkg::TEMP_REF;
   assign s3_vl_in   = $signed({s3_dtemp[18], s3_dtemp}) + bptc_pkg::VERY_COLD_BIAS;
   assign s3_off_in  = $signed({4'd0, cal.pressure_offset, 17'd0})
                     + $signed({s2_mo_ff[41], s2_mo_ff[41:6]});
   assign s3_sens_in = $signed({4'd0, cal.pressure_sensitivity, 16'd0})
                     + $signed({s2_ms_ff[41], s2_ms_ff[41:7]});

   always_ff @(posedge clock) begin
      s3_d1_ff    <= s2_d1_ff;
      s3_temp_ff  <= s3_temp_in;
      s3_lo_ff    <= s3_dtemp;
      s3_vl_ff    <= s3_vl_in;
      s3_off_ff   <= s3_off_in;
      s3_sens_ff  <= s3_sens_in;
      s3_t2_ff    <= s2_mdd_ff[48:31];
      s3_cold_ff  <= s3_dtemp[18];     // TEMP below 20.00 C
      s3_vcold_ff <= s3_vl_in[19];     // TEMP below -15.00 C
   end

   // ---------------- stage 4: squares of the two temperature offsets
   logic        [23:0] s4_d1_ff;
   logic signed [18:0] s4_temp_ff;
   logic signed [36:0] s4_off_ff;
   logic signed [35:0] s4_sens_ff;
   logic        [17:0] s4_t2_ff;
   logic               s4_cold_ff, s4_vcold_ff;
   logic signed [37:0] s4_lo_prod;
   logic signed [39:0] s4_vl_prod;
   logic        [33:0] s4_lo_sq_ff, s4_vl_sq_ff;

   assign s4_lo_prod = s3_lo_ff * s3_lo_ff;
   assign s4_vl_prod = s3_vl_ff * s3_vl_ff;

   always_ff @(posedge clock) begin
      s4_d1_ff    <= s3_d1_ff;
      s4_temp_ff  <= s3_temp_ff;
      s4_off_ff   <= s3_off_ff;
      s4_sens_ff  <= s3_sens_ff;
      s4_t2_ff    <= s3_t2_ff;
      s4_cold_ff  <= s3_cold_ff;
      s4_vcold_ff <= s3_vcold_ff;
      // squares stay below 2^34 whenever they are used
      s4_lo_sq_ff <= s4_lo_prod[33:0];
      s4_vl_sq_ff <= s4_vl_prod[33:0];
   end

   // ---------------- stage 5: OFF2, SENS2, gated T2
   logic        [23:0] s5_d1_ff;
   logic signed [18:0] s5_temp_ff;
   logic signed [36:0] s5_off_ff;
   logic signed [35:0] s5_sens_ff;
   logic        [39:0] s5_lo61;
   logic        [37:0] s5_vl15;
   logic        [38:0] s5_off2_ff, s5_off2_in;
   logic        [37:0] s5_sens2_ff, s5_sens2_in;
   logic        [17:0] s5_t2_ff, s5_t2_in;

   assign s5_lo61 = {6'd0, s4_lo_sq_ff} * 40'd61;
   assign s5_vl15 = {4'd0, s4_vl_sq_ff} * 38'd15;

   always_comb begin
      s5_off2_in  = {3'd0, s5_lo61[39:4]};
      s5_sens2_in = {3'd0, s4_lo_sq_ff, 1'b0};
      s5_t2_in    = s4_t2_ff;
      if (s4_vcold_ff) begin
         s5_off2_in  = s5_off2_in + {1'b0, s5_vl15};
         s5_sens2_in = s5_sens2_in + {1'b0, s4_vl_sq_ff, 3'd0};
      end
      if (!s4_cold_ff) begin
         s5_off2_in  = '0;
         s5_sens2_in = '0;
         s5_t2_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      s5_d1_ff    <= s4_d1_ff;
      s5_temp_ff  <= s4_temp_ff;
      s5_off_ff   <= s4_off_ff;
      s5_sens_ff  <= s4_sens_ff;
      s5_off2_ff  <= s5_off2_in;
      s5_sens2_ff <= s5_sens2_in;
      s5_t2_ff    <= s5_t2_in;
   end

   // ---------------- stage 6: apply second-order terms
   logic        [23:0] s6_d1_ff;
   logic signed [18:0] s6_temp_ff, s6_temp_in;
   logic signed [40:0] s6_off_ff, s6_off_in;
   logic signed [39:0] s6_sens_ff, s6_sens_in;

   assign s6_temp_in = s5_temp_ff - $signed({1'b0, s5_t2_ff});
   assign s6_off_in  = $signed({{4{s5_off_ff[36]}}, s5_off_ff})
                     - $signed({2'd0, s5_off2_ff});
   assign s6_sens_in = $signed({{4{s5_sens_ff[35]}}, s5_sens_ff})
                     - $signed({2'd0, s5_sens2_ff});

   always_ff @(posedge clock) begin
      s6_d1_ff   <= s5_d1_ff;
      s6_temp_ff <= s6_temp_in;
      s6_off_ff  <= s6_off_in;
      s6_sens_ff <= s6_sens_in;
   end

   // ---------------- stage 7: D1 * SENS as two partial products
   logic signed [18:0] s7_temp_ff;
   logic signed [40:0] s7_off_ff;
   logic        [43:0] s7_pp_lo_ff, s7_pp_lo_in;
   logic signed [44:0] s7_pp_hi_ff, s7_pp_hi_in;

   assign s7_pp_lo_in = s6_d1_ff * s6_sens_ff[19:0];
   assign s7_pp_hi_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[39:20]);

   always_ff @(posedge clock) begin
      s7_temp_ff  <= s6_temp_ff;
      s7_off_ff   <= s6_off_ff;
      s7_pp_lo_ff <= s7_pp_lo_in;
      s7_pp_hi_ff <= s7_pp_hi_in;
   end

   // ---------------- stage 8: recombine the product
   logic signed [18:0] s8_temp_ff;
   logic signed [40:0] s8_off_ff;
   logic signed [64:0] s8_prod_in;
   logic signed [63:0] s8_prod_ff;

   assign s8_prod_in = $signed({s7_pp_hi_ff, 20'd0}) + $signed({21'd0, s7_pp_lo_ff});

   always_ff @(posedge clock) begin
      s8_temp_ff <= s7_temp_ff;
      s8_off_ff  <= s7_off_ff;
      s8_prod_ff <= s8_prod_in[63:0];
   end

   // ---------------- stage 9: D1*SENS/2^21 - OFF
   logic signed [18:0] s9_temp_ff;
   logic signed [43:0] s9_x_ff, s9_x_in;

   assign s9_x_in = $signed({s8_prod_ff[63], s8_prod_ff[63:21]})
                  - $signed({{3{s8_off_ff[40]}}, s8_off_ff});

   always_ff @(posedge clock) begin
      s9_temp_ff <= s8_temp_ff;
      s9_x_ff    <= s9_x_in;
   end

   // ---------------- stage 10: scale, range flags, output register
   logic signed [28:0] s10_p;
   logic               s10_p_bad, s10_t_bad;
   logic signed [31:0] rsp_press_ff;
   logic signed [18:0] rsp_temp_ff;
   logic               rsp_p_bad_ff, rsp_t_bad_ff;

   // P is the 29-bit slice, sign-extended to the signed 32-bit output; there is no clamp
   assign s10_p     = $signed(s9_x_ff[43:15]);
   assign s10_p_bad = (s10_p < bptc_pkg::PRESS_LO_LIMIT) || (s10_p > bptc_pkg::PRESS_HI_LIMIT);
   assign s10_t_bad = (s9_temp_ff < bptc_pkg::TEMP_LO_LIMIT)
                   || (s9_temp_ff > bptc_pkg::TEMP_HI_LIMIT);

   always_ff @(posedge clock) begin
      rsp_press_ff <= $signed({{3{s10_p[28]}}, s10_p});
      rsp_temp_ff  <= s9_temp_ff;
      rsp_p_bad_ff <= s10_p_bad;
      rsp_t_bad_ff <= s10_t_bad;
   end

   assign rsp_valid                    = vld_ff[bptc_pkg::LATENCY-1];
   assign rsp_pressure_centi_mbar      = rsp_press_ff;
   assign rsp_temperature_centi_c      = rsp_temp_ff;
   assign rsp_pressure_out_of_range    = rsp_p_bad_ff;
   assign rsp_temperature_out_of_range = rsp_t_bad_ff;

endmodule

`default_nettype wire
